// ----- src/clock_set_key_controller_macros.svh -----
// Assertion macros shared by the clock set key controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CLOCK_SET_KEY_CONTROLLER_MACROS_SVH
`define CLOCK_SET_KEY_CONTROLLER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define CSKC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("cskc: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define CSKC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("cskc: next-cycle check failed");

`endif

// ----- src/cskc_pkg.sv -----
// Types, constants and field stepping functions for the clock set key controller.
// Depends on nothing; used by cskc_keys, cskc_fields, cskc_outq, the top level and the bench.
package cskc_pkg;

	localparam int unsigned CfgW = 8;
	localparam int unsigned CfgIdxW = 2;

	// Register reset values
	localparam logic [CfgW-1:0] DebounceRst = 8'd5;
	localparam logic [CfgW-1:0] LongPressRst = 8'd100;
	localparam logic [CfgW-1:0] RepeatGapRst = 8'd50;
	localparam logic [CfgW-1:0] CountLimitRst = 8'hf0;

	// Clock field reset values
	localparam logic [4:0] HourRst = 5'd22;
	localparam logic [5:0] MinuteRst = 6'd6;
	localparam logic [5:0] SecondRst = 6'd33;
	localparam logic [4:0] DayRst = 5'd25;
	localparam logic [3:0] MonthRst = 4'd12;
	localparam logic [15:0] YearRst = 16'd2005;
	localparam logic [2:0] WeekdayRst = 3'd7;

	// Field limits
	localparam logic [5:0] MinuteMax = 6'd59;
	localparam logic [4:0] HourMax = 5'd23;
	localparam logic [4:0] DayMax = 5'd31;
	localparam logic [4:0] MonthOver = 5'd13;
	localparam logic [3:0] MonthMax = 4'd12;
	localparam logic [2:0] WeekdayMax = 3'd7;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_REPEAT_GAP = 2'd2,
		CFG_COUNT_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_TIME = 3'd0,
		MODE_DATE = 3'd1,
		MODE_YEAR = 3'd2,
		MODE_WDAY = 3'd3,
		MODE_OFF = 3'd4
	} mode_t;

	// Key actions decided for one beat
	typedef struct packed {
		logic sel;
		logic plus;
		logic minus;
		logic any;
	} act_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [4:0] day;
		logic [3:0] month;
		logic [15:0] year;
		logic [2:0] weekday;
	} fields_t;

	typedef struct packed {
		fields_t fld;
		logic [2:0] mode;
		logic changed;
	} result_t;

	// Step the chosen field up by one, with wraps
	function automatic fields_t step_plus(input fields_t f, input mode_t m);
		fields_t r;
		logic [4:0] mon;
		r = f;
		mon = {1'b0, f.month};
		unique case (m)
			MODE_TIME: begin
				if (f.minute >= MinuteMax) begin
					r.minute = '0;
					r.hour = (f.hour >= HourMax) ? 5'd0 : f.hour + 5'd1;
				end else begin
					r.minute = f.minute + 6'd1;
				end
			end
			MODE_DATE: begin
				if (f.day >= DayMax) begin
					r.day = 5'd1;
					mon = mon + 5'd1;
				end else begin
					r.day = f.day + 5'd1;
				end
				r.month = (mon >= MonthOver) ? 4'd1 : mon[3:0];
			end
			MODE_YEAR: r.year = f.year + 16'd1;
			MODE_WDAY: r.weekday = (f.weekday >= WeekdayMax) ? 3'd1 : f.weekday + 3'd1;
			default: ;
		endcase
		return r;
	endfunction

	// Step the chosen field down by one, with wraps
	function automatic fields_t step_minus(input fields_t f, input mode_t m);
		fields_t r;
		r = f;
		unique case (m)
			MODE_TIME: begin
				if (f.minute == 6'd0) begin
					r.minute = MinuteMax;
					r.hour = (f.hour == 5'd0) ? HourMax : f.hour - 5'd1;
				end else begin
					r.minute = f.minute - 6'd1;
				end
			end
			MODE_DATE: begin
				if (f.day <= 5'd1) begin
					r.day = DayMax;
					r.month = (f.month <= 4'd1) ? MonthMax : f.month - 4'd1;
				end else begin
					r.day = f.day - 5'd1;
				end
			end
			MODE_YEAR: r.year = f.year - 16'd1;
			MODE_WDAY: r.weekday = (f.weekday <= 3'd1) ? WeekdayMax : f.weekday - 3'd1;
			default: ;
		endcase
		return r;
	endfunction

	// Saturating hold counter update, cleared while the key is released
	function automatic logic [CfgW-1:0] hold_next(input logic [CfgW-1:0] cnt, input logic lvl,
			input logic [CfgW-1:0] limit);
		logic [CfgW-1:0] r;
		r = '0;
		if (lvl) begin
			r = (cnt < limit) ? cnt + 8'd1 : cnt;
		end
		return r;
	endfunction

endpackage

// ----- src/cskc_key_if.sv -----
// Key tick channel: valid/ready handshake carrying the three key levels.
// Depends on nothing.
interface cskc_key_if;
	logic valid;
	logic ready;
	logic minus_pressed;
	logic plus_pressed;
	logic select_pressed;

	modport source (output valid, output minus_pressed, output plus_pressed,
		output select_pressed, input ready);
	modport sink (input valid, input minus_pressed, input plus_pressed,
		input select_pressed, output ready);
endinterface

// ----- src/cskc_disp_if.sv -----
// Result channel: valid/ready handshake carrying the clock fields, mode and change flag.
// Depends on nothing.
interface cskc_disp_if;
	logic valid;
	logic ready;
	logic [4:0] hour_out;
	logic [5:0] minute_out;
	logic [5:0] second_out;
	logic [4:0] day_out;
	logic [3:0] month_out;
	logic [15:0] year_out;
	logic [2:0] weekday_out;
	logic [2:0] mode_out;
	logic changed;

	modport source (output valid, output hour_out, output minute_out, output second_out,
		output day_out, output month_out, output year_out, output weekday_out,
		output mode_out, output changed, input ready);
	modport sink (input valid, input hour_out, input minute_out, input second_out,
		input day_out, input month_out, input year_out, input weekday_out,
		input mode_out, input changed, output ready);
endinterface

// ----- src/cskc_keys.sv -----
// Key front end: config registers, hold counters, heartbeat and action decision.
// Depends on cskc_pkg.
module cskc_keys (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cskc_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [cskc_pkg::CfgW-1:0]             cfg_wdata,
	input  logic                                  accept,
	input  logic                                  minus_lvl,
	input  logic                                  plus_lvl,
	input  logic                                  select_lvl,
	output cskc_pkg::act_t                        act
);

	logic [cskc_pkg::CfgW-1:0] debounce_q, long_press_q, repeat_gap_q, count_limit_q;
	logic [cskc_pkg::CfgW-1:0] minus_hold_q, plus_hold_q, select_hold_q;
	logic [cskc_pkg::CfgW-1:0] heartbeat_q, last_change_q;
	logic [cskc_pkg::CfgW-1:0] minus_nxt, plus_nxt, select_nxt, hb_nxt, since;
	logic any_long, gap_open, armed;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= cskc_pkg::DebounceRst;
			long_press_q <= cskc_pkg::LongPressRst;
			repeat_gap_q <= cskc_pkg::RepeatGapRst;
			count_limit_q <= cskc_pkg::CountLimitRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cskc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata;
				cskc_pkg::CFG_LONG_PRESS: long_press_q <= cfg_wdata;
				cskc_pkg::CFG_REPEAT_GAP: repeat_gap_q <= cfg_wdata;
				cskc_pkg::CFG_COUNT_LIMIT: count_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Work out the counters after this beat and which keys act
	always_comb begin
		minus_nxt = cskc_pkg::hold_next(minus_hold_q, minus_lvl, count_limit_q);
		plus_nxt = cskc_pkg::hold_next(plus_hold_q, plus_lvl, count_limit_q);
		select_nxt = cskc_pkg::hold_next(select_hold_q, select_lvl, count_limit_q);
		hb_nxt = heartbeat_q + 8'd1;
		since = hb_nxt - last_change_q;
		any_long = (plus_nxt >= long_press_q) || (minus_nxt >= long_press_q) ||
			(select_nxt >= long_press_q);
		gap_open = since >= repeat_gap_q;
		armed = any_long || gap_open;
		act.sel = armed && (select_nxt > debounce_q);
		act.plus = armed && (plus_nxt > debounce_q);
		act.minus = armed && (minus_nxt > debounce_q);
		act.any = act.sel || act.plus || act.minus;
	end

	// Advance counters on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minus_hold_q <= '0;
			plus_hold_q <= '0;
			select_hold_q <= '0;
			heartbeat_q <= '0;
			last_change_q <= '0;
		end else if (accept) begin
			minus_hold_q <= minus_nxt;
			plus_hold_q <= plus_nxt;
			select_hold_q <= select_nxt;
			heartbeat_q <= hb_nxt;
			if (act.any) begin
				last_change_q <= hb_nxt;
			end
		end
	end

endmodule

// ----- src/cskc_fields.sv -----
// Adjust mode and clock field registers, stepped by the key actions of each beat.
// Depends on cskc_pkg and the assertion macro header.
`include "clock_set_key_controller_macros.svh"

module cskc_fields (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cskc_pkg::act_t    act,
	output cskc_pkg::result_t res
);

	cskc_pkg::mode_t mode_q, mode_nxt;
	cskc_pkg::fields_t fld_q, fld_up, fld_dn, fld_nxt;

	// Cycle the mode, then step the chosen field up and down in that order
	always_comb begin
		mode_nxt = mode_q;
		if (act.sel) begin
			mode_nxt = (mode_q >= cskc_pkg::MODE_OFF) ? cskc_pkg::MODE_TIME :
				cskc_pkg::mode_t'(mode_q + 3'd1);
		end
		fld_up = act.plus ? cskc_pkg::step_plus(fld_q, mode_nxt) : fld_q;
		fld_dn = act.minus ? cskc_pkg::step_minus(fld_up, mode_nxt) : fld_up;
		fld_nxt = fld_dn;
		// A minute change drops the seconds
		if ((mode_nxt == cskc_pkg::MODE_TIME) && (act.plus || act.minus)) begin
			fld_nxt.second = '0;
		end
		res.fld = fld_nxt;
		res.mode = mode_nxt;
		res.changed = act.any;
	end

	// Hold the new values on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cskc_pkg::MODE_TIME;
			fld_q.hour <= cskc_pkg::HourRst;
			fld_q.minute <= cskc_pkg::MinuteRst;
			fld_q.second <= cskc_pkg::SecondRst;
			fld_q.day <= cskc_pkg::DayRst;
			fld_q.month <= cskc_pkg::MonthRst;
			fld_q.year <= cskc_pkg::YearRst;
			fld_q.weekday <= cskc_pkg::WeekdayRst;
		end else if (accept) begin
			mode_q <= mode_nxt;
			fld_q <= fld_nxt;
		end
	end

	`CSKC_ASSERT_NEXT(a_idle_beat_keeps_fields, clk, arst_n, accept && !act.any, $stable(fld_q) && $stable(mode_q))
	`CSKC_ASSERT_NOW(a_date_in_range, clk, arst_n, 1'b1, fld_q.day >= 5'd1 && fld_q.day <= cskc_pkg::DayMax && fld_q.month >= 4'd1 && fld_q.month <= cskc_pkg::MonthMax)
	`CSKC_ASSERT_NEXT(a_minute_step_clears_sec, clk, arst_n, accept && mode_nxt == cskc_pkg::MODE_TIME && (act.plus || act.minus), fld_q.second == 6'd0)

endmodule

// ----- src/cskc_outq.sv -----
// Two-entry result buffer between the field logic and the result channel.
// Depends on cskc_pkg and cskc_disp_if.
module cskc_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cskc_pkg::result_t    push_data,
	output logic                 room,
	cskc_disp_if.source          disp
);

	cskc_pkg::result_t buf_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;
	cskc_pkg::result_t head;

	assign room = cnt_q != 2'd2;
	assign pop = (cnt_q != 2'd0) && disp.ready;
	assign head = buf_q[rd_ptr_q];

	// Store the result of each accepted beat
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Drive the oldest result onto the channel
	always_comb begin
		disp.valid = cnt_q != 2'd0;
		disp.hour_out = head.fld.hour;
		disp.minute_out = head.fld.minute;
		disp.second_out = head.fld.second;
		disp.day_out = head.fld.day;
		disp.month_out = head.fld.month;
		disp.year_out = head.fld.year;
		disp.weekday_out = head.fld.weekday;
		disp.mode_out = head.mode;
		disp.changed = head.changed;
	end

endmodule

// ----- src/clock_set_key_controller.sv -----
// Top level of the clock set key controller: key front end, field registers, result buffer.
// Depends on cskc_pkg, cskc_key_if, cskc_disp_if, cskc_keys, cskc_fields, cskc_outq, macro header.
//
// One key beat (a 5 ms tick carrying the minus, plus and select levels) is taken per clock
// cycle while the result buffer has a free entry. The hold counters, heartbeat, adjust mode
// and clock fields are all updated in the cycle the beat is accepted, by one pass of compare
// and increment logic, and the resulting fields, mode and change flag are written into the
// result buffer, whose oldest entry drives the result channel. A two-entry result buffer
// lets beats keep flowing while a result waits; the key channel stalls only when both
// entries are held. Configuration writes (debounce minimum, long press, repeat gap, count
// limit) take effect on the next beat and are expected only while no beat is in flight.
`include "clock_set_key_controller_macros.svh"

module clock_set_key_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cskc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [cskc_pkg::CfgW-1:0]      cfg_wdata,
	cskc_key_if.sink                       key,
	cskc_disp_if.source                    disp
);

	logic accept;
	logic room;
	cskc_pkg::act_t act;
	cskc_pkg::result_t res;

	// Accept a beat whenever the buffer has a free entry
	assign key.ready = room;
	assign accept = key.valid && room;

	cskc_keys u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.minus_lvl  (key.minus_pressed),
		.plus_lvl   (key.plus_pressed),
		.select_lvl (key.select_pressed),
		.act        (act)
	);

	cskc_fields u_fields (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.act    (act),
		.res    (res)
	);

	cskc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.room      (room),
		.disp      (disp)
	);

	`CSKC_ASSERT_NOW(a_stall_means_result_waiting, clk, arst_n, !key.ready, disp.valid)
	`CSKC_ASSERT_NEXT(a_beat_yields_result, clk, arst_n, accept, disp.valid)
	`CSKC_ASSERT_NOW(a_change_needs_key, clk, arst_n, accept && act.any, key.minus_pressed || key.plus_pressed || key.select_pressed)

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the clock set key controller: beats of key levels in, display values out.
// Depends on cskc_pkg, cskc_key_if, cskc_disp_if and the clock_set_key_controller top level.
module tb;

	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic minus;
		logic plus;
		logic sel;
	} keys_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [cskc_pkg::CfgIdxW-1:0] cfg_index;
	logic [cskc_pkg::CfgW-1:0] cfg_wdata;

	cskc_key_if key_ch ();
	cskc_disp_if disp_ch ();

	clock_set_key_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.key(key_ch),
		.disp(disp_ch)
	);

	// Own copy of the settings and of the keypad state
	logic [7:0] debounce_min, long_press, repeat_gap, count_limit;
	logic [7:0] minus_hold, plus_hold, select_hold, heartbeat, last_change;
	cskc_pkg::mode_t mode;
	cskc_pkg::fields_t clk_fld;

	keys_t key_backlog[$];
	cskc_pkg::result_t display_due[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic key_taken;
	int unsigned mismatches;
	int unsigned beats_taken;
	int unsigned actions_seen;
	int unsigned settings_used;
	int unsigned cycle_count;

	always #5 clk = ~clk;

	function automatic void reset_model();
		debounce_min = 8'd5;
		long_press = 8'd100;
		repeat_gap = 8'd50;
		count_limit = 8'd240;
		minus_hold = '0;
		plus_hold = '0;
		select_hold = '0;
		heartbeat = '0;
		last_change = '0;
		mode = cskc_pkg::MODE_TIME;
		clk_fld.hour = 5'd22;
		clk_fld.minute = 6'd6;
		clk_fld.second = 6'd33;
		clk_fld.day = 5'd25;
		clk_fld.month = 4'd12;
		clk_fld.year = 16'd2005;
		clk_fld.weekday = 3'd7;
	endfunction

	function automatic logic [7:0] bump_hold(input logic [7:0] cnt, input logic lvl);
		if (!lvl)
			return 8'd0;
		return (cnt < count_limit) ? cnt + 8'd1 : cnt;
	endfunction

	// Step the field chosen by the mode; report whether the minute was touched
	function automatic logic nudge_field(input logic up);
		logic minute_hit;
		minute_hit = 1'b0;
		case (mode)
			cskc_pkg::MODE_TIME: begin
				minute_hit = 1'b1;
				if (up) begin
					if (clk_fld.minute >= 6'd59) begin
						clk_fld.minute = 6'd0;
						clk_fld.hour = (clk_fld.hour >= 5'd23) ? 5'd0 : clk_fld.hour + 5'd1;
					end else begin
						clk_fld.minute = clk_fld.minute + 6'd1;
					end
				end else if (clk_fld.minute == 6'd0) begin
					clk_fld.minute = 6'd59;
					clk_fld.hour = (clk_fld.hour == 5'd0) ? 5'd23 : clk_fld.hour - 5'd1;
				end else begin
					clk_fld.minute = clk_fld.minute - 6'd1;
				end
			end
			cskc_pkg::MODE_DATE: begin
				if (up) begin
					if (clk_fld.day >= 5'd31) begin
						clk_fld.day = 5'd1;
						clk_fld.month = clk_fld.month + 4'd1;
					end else begin
						clk_fld.day = clk_fld.day + 5'd1;
					end
					if (clk_fld.month >= 4'd13)
						clk_fld.month = 4'd1;
				end else if (clk_fld.day <= 5'd1) begin
					clk_fld.day = 5'd31;
					clk_fld.month = (clk_fld.month <= 4'd1) ? 4'd12 : clk_fld.month - 4'd1;
				end else begin
					clk_fld.day = clk_fld.day - 5'd1;
				end
			end
			cskc_pkg::MODE_YEAR:
				clk_fld.year = up ? clk_fld.year + 16'd1 : clk_fld.year - 16'd1;
			cskc_pkg::MODE_WDAY: begin
				if (up)
					clk_fld.weekday = (clk_fld.weekday >= 3'd7) ? 3'd1 : clk_fld.weekday + 3'd1;
				else
					clk_fld.weekday = (clk_fld.weekday <= 3'd1) ? 3'd7 : clk_fld.weekday - 3'd1;
			end
			default: ;
		endcase
		return minute_hit;
	endfunction

	// Advance the keypad by one tick and return the display values it leaves
	function automatic cskc_pkg::result_t tick_clock(input keys_t k);
		cskc_pkg::result_t r;
		logic [7:0] since;
		logic acted;
		logic minute_hit;
		acted = 1'b0;
		minute_hit = 1'b0;
		minus_hold = bump_hold(minus_hold, k.minus);
		plus_hold = bump_hold(plus_hold, k.plus);
		select_hold = bump_hold(select_hold, k.sel);
		heartbeat = heartbeat + 8'd1;
		since = heartbeat - last_change;
		if (minus_hold >= long_press || plus_hold >= long_press ||
				select_hold >= long_press || since >= repeat_gap) begin
			if (select_hold > debounce_min) begin
				acted = 1'b1;
				mode = (mode >= cskc_pkg::MODE_OFF) ? cskc_pkg::MODE_TIME :
					cskc_pkg::mode_t'(mode + 3'd1);
			end
			if (plus_hold > debounce_min) begin
				acted = 1'b1;
				minute_hit = nudge_field(1'b1) | minute_hit;
			end
			if (minus_hold > debounce_min) begin
				acted = 1'b1;
				minute_hit = nudge_field(1'b0) | minute_hit;
			end
			if (acted) begin
				if (minute_hit)
					clk_fld.second = 6'd0;
				last_change = heartbeat;
			end
		end
		r.fld = clk_fld;
		r.mode = mode;
		r.changed = acted;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Feed key beats from the backlog, with random sender gaps and receiver stalls
	always @(negedge clk) begin
		keys_t nxt;
		if (!arst_n) begin
			key_ch.valid <= 1'b0;
		end else if (!key_ch.valid || key_taken) begin
			if (key_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = key_backlog.pop_front();
				key_ch.valid <= 1'b1;
				key_ch.minus_pressed <= nxt.minus;
				key_ch.plus_pressed <= nxt.plus;
				key_ch.select_pressed <= nxt.sel;
			end else begin
				key_ch.valid <= 1'b0;
			end
		end
		disp_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Check each display beat against the oldest prediction, then predict new key beats
	always @(posedge clk) begin
		cskc_pkg::result_t want;
		keys_t k;
		if (arst_n) begin
			if (disp_ch.valid && disp_ch.ready) begin
				if (display_due.size() == 0) begin
					$error("display beat with nothing expected");
					mismatches++;
				end else begin
					want = display_due.pop_front();
					check_field("hour_out", want.fld.hour, disp_ch.hour_out);
					check_field("minute_out", want.fld.minute, disp_ch.minute_out);
					check_field("second_out", want.fld.second, disp_ch.second_out);
					check_field("day_out", want.fld.day, disp_ch.day_out);
					check_field("month_out", want.fld.month, disp_ch.month_out);
					check_field("year_out", want.fld.year, disp_ch.year_out);
					check_field("weekday_out", want.fld.weekday, disp_ch.weekday_out);
					check_field("mode_out", want.mode, disp_ch.mode_out);
					check_field("changed", want.changed, disp_ch.changed);
					if (want.changed)
						actions_seen++;
				end
			end
			if (key_ch.valid && key_ch.ready) begin
				k.minus = key_ch.minus_pressed;
				k.plus = key_ch.plus_pressed;
				k.sel = key_ch.select_pressed;
				display_due.push_back(tick_clock(k));
				beats_taken++;
			end
		end
		key_taken <= arst_n && key_ch.valid && key_ch.ready;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic void push_keys(input logic minus, input logic plus, input logic sel,
			input int unsigned beats);
		keys_t k;
		k.minus = minus;
		k.plus = plus;
		k.sel = sel;
		repeat (beats) key_backlog.push_back(k);
	endfunction

	// Hold the sender until every expected display beat is in
	task automatic drain_display();
		while (key_backlog.size() != 0 || key_ch.valid || display_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] deb, input logic [7:0] lng,
			input logic [7:0] gap, input logic [7:0] lim);
		logic [7:0] vals[4];
		vals = '{deb, lng, gap, lim};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= cskc_pkg::cfg_idx_t'(i);
			cfg_wdata <= vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		debounce_min = deb;
		long_press = lng;
		repeat_gap = gap;
		count_limit = lim;
		settings_used++;
	endtask

	// Mostly press-and-release runs of random keys, with stray and clipped presses mixed in
	task automatic queue_key_play(input int unsigned beats);
		int unsigned queued;
		int unsigned pick;
		int unsigned len;
		keys_t k;
		queued = 0;
		while (queued < beats) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				k = keys_t'(3'($urandom_range(7)));
				len = 1;
			end else begin
				if ($urandom_range(99) < 60)
					k = keys_t'(3'b001 << $urandom_range(2));
				else
					k = keys_t'(3'($urandom_range(7, 1)));
				if (pick < 20)
					len = $urandom_range(3, 1);
				else if ($urandom_range(99) < 15)
					len = $urandom_range(150, 40);
				else
					len = $urandom_range(30, 1);
			end
			push_keys(k.minus, k.plus, k.sel, len);
			queued += len;
			if (pick >= 12) begin
				len = $urandom_range(20, 0);
				push_keys(1'b0, 1'b0, 1'b0, len);
				queued += len;
			end
		end
	endtask

	initial begin
		logic [7:0] plan[8][4];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cskc_pkg::CFG_DEBOUNCE;
		cfg_wdata = '0;
		key_ch.valid = 1'b0;
		key_ch.minus_pressed = 1'b0;
		key_ch.plus_pressed = 1'b0;
		key_ch.select_pressed = 1'b0;
		disp_ch.ready = 1'b0;
		key_taken = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		beats_taken = 0;
		actions_seen = 0;
		settings_used = 0;
		cycle_count = 0;
		reset_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: nothing acts this early
		push_keys(1'b0, 1'b0, 1'b0, 1);
		push_keys(1'b1, 1'b1, 1'b1, 1);
		push_keys(1'b1, 1'b0, 1'b0, 1);
		push_keys(1'b0, 1'b1, 1'b0, 1);
		drain_display();

		// Every held key acts on every tick: walk all modes and the small wraps
		load_settings(8'd0, 8'd255, 8'd0, 8'd255);
		push_keys(1'b0, 1'b0, 1'b1, 5);
		push_keys(1'b0, 1'b0, 1'b0, 1);
		push_keys(1'b0, 1'b1, 1'b0, 1);
		push_keys(1'b1, 1'b0, 1'b0, 1);
		push_keys(1'b1, 1'b1, 1'b0, 1);
		push_keys(1'b0, 1'b0, 1'b0, 1);
		push_keys(1'b0, 1'b0, 1'b1, 1);
		push_keys(1'b0, 1'b1, 1'b0, 1);
		push_keys(1'b1, 1'b0, 1'b0, 1);
		push_keys(1'b0, 1'b1, 1'b1, 1);
		push_keys(1'b1, 1'b0, 1'b1, 1);
		push_keys(1'b0, 1'b1, 1'b0, 1);
		push_keys(1'b0, 1'b0, 1'b0, 1);
		push_keys(1'b0, 1'b1, 1'b0, 1);
		push_keys(1'b1, 1'b0, 1'b0, 1);
		push_keys(1'b1, 1'b1, 1'b1, 1);
		push_keys(1'b0, 1'b0, 1'b1, 1);
		drain_display();

		// Random play under a spread of settings and handshake pressure
		plan = '{
			'{8'd5, 8'd100, 8'd50, 8'd240},
			'{8'd0, 8'd0, 8'd0, 8'd255},
			'{8'd255, 8'd255, 8'd255, 8'd255},
			'{8'd2, 8'd20, 8'd8, 8'd30},
			'{8'd0, 8'd255, 8'd255, 8'd0},
			'{8'd1, 8'd3, 8'd4, 8'd10},
			'{8'($urandom_range(6)), 8'($urandom_range(60)),
				8'($urandom_range(20)), 8'($urandom_range(255, 1))},
			'{8'd0, 8'd0, 8'd255, 8'd255}
		};
		for (int p = 0; p < 8; p++) begin
			load_settings(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 79; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 79; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			queue_key_play(120);
			drain_display();
		end

		$display("%0d key beats checked over %0d settings, %0d of them with a key action",
			beats_taken, settings_used, actions_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/cskc_pkg.sv
src/cskc_key_if.sv
src/cskc_disp_if.sv
src/cskc_keys.sv
src/cskc_fields.sv
src/cskc_outq.sv
src/clock_set_key_controller.sv
test/tb.sv
